@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL; they compile to nothing under SYNTHESIS.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Plain clocked property, disabled while reset is asserted (active low).
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Antecedent in this cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/cmwc_pkg.sv @@
// Shared types and constants for the CMWC random generator.
// No dependencies.
package cmwc_pkg;

    // Ring depth; the index arithmetic wraps by truncation, so keep it a power of two.
    localparam int RING_SIZE = 16;
    localparam int RING_AW   = $clog2(RING_SIZE);

    localparam int WORD_W    = 32;
    localparam int LAG_W     = 5;
    localparam int SLOT_W    = 4;
    localparam int POS_W     = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [WORD_W-1:0] MULT_RESET = 32'd1000000407;
    localparam logic [LAG_W-1:0]  LAG_RESET  = 5'd16;
    localparam logic [WORD_W-1:0] WORD_BIAS  = 32'h7fff_ffff;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MULT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAG  = 1'b1;

    typedef enum logic [1:0] {
        OP_DRAW  = 2'd0,
        OP_WRITE = 2'd1,
        OP_SET   = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] load_value;
    } t_in_req;

    typedef struct packed {
        logic [WORD_W-1:0] out_word;
        logic [WORD_W-1:0] out_carry;
        logic [POS_W-1:0]  out_position;
    } t_out_rsp;

endpackage

@@ rtl/core/cmwc_mac.sv @@
// One multiply-with-carry step: t = mult * word + carry, word' = bias - t[31:0].
// Depends on cmwc_pkg.
module cmwc_mac (
    input  logic [cmwc_pkg::WORD_W-1:0] i_mult,
    input  logic [cmwc_pkg::WORD_W-1:0] i_word,
    input  logic [cmwc_pkg::WORD_W-1:0] i_carry,
    output logic [cmwc_pkg::WORD_W-1:0] o_word,
    output logic [cmwc_pkg::WORD_W-1:0] o_carry
);
    import cmwc_pkg::*;

    logic [2*WORD_W-1:0] sum;

    // 32x32 product plus carry never overflows 64 bits
    assign sum     = (2*WORD_W)'(i_mult) * (2*WORD_W)'(i_word) + (2*WORD_W)'(i_carry);
    assign o_word  = WORD_BIAS - sum[WORD_W-1:0];
    assign o_carry = sum[2*WORD_W-1:WORD_W];

endmodule

@@ rtl/core/cmwc_random_generator.sv @@
// CMWC random generator: lag-r complementary multiply-with-carry over a 16-word ring.
// One request per cycle, unless warm-up draws or i_out_stall hold the request in the request register.
// Unless a write or set comes first, the first draw after reset runs lag discarded MAC draws, one per cycle.
// Reset (synchronous, active low): ring[i] = i, carry 0, position 0, warm-up pending,
// multiplier 1000000407, lag 16; both pipeline registers empty, request stall held high.
// Depends on cmwc_pkg, cmwc_mac and assert_macros.svh.
`include "assert_macros.svh"

module cmwc_random_generator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [cmwc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cmwc_pkg::WORD_W-1:0]    i_cfg_data,
    // request channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  cmwc_pkg::t_in_req              i_in,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output cmwc_pkg::t_out_rsp             o_out
);
    import cmwc_pkg::*;

    // Pipeline: request register -> (state update + MAC) -> result register.
    // The generator state lives beside the second stage and is updated in the
    // same cycle the result is registered (warm-up draws update it with no result), so
    // back-to-back draws see the previous draw's ring word and carry with no forwarding.

    logic [WORD_W-1:0]  r_ring [RING_SIZE];
    logic [WORD_W-1:0]  r_carry;
    logic [RING_AW-1:0] r_pos;
    logic               r_warm;     // warm-up still owed before the first draw
    logic [LAG_W-1:0]   r_wcnt;     // discarded draws done so far
    logic [WORD_W-1:0]  r_mult;
    logic [LAG_W-1:0]   r_lag;

    logic               r_in_vld;
    t_in_req            r_in;
    logic               r_out_vld;
    t_out_rsp           r_out;

    logic [RING_AW-1:0] slot_idx;
    logic [RING_AW-1:0] lag_idx;
    logic [RING_AW-1:0] rd_addr;
    logic [WORD_W-1:0]  rd_word;
    logic [WORD_W-1:0]  mac_word;
    logic [WORD_W-1:0]  mac_carry;
    logic               is_draw;
    logic               warm_busy;
    logic               out_ready;
    logic               consume;
    logic               do_draw;
    logic               in_take;

    logic [WORD_W-1:0]  n_carry;
    logic [RING_AW-1:0] n_pos;
    logic               n_warm;
    logic [WORD_W-1:0]  n_word;

    assign slot_idx = RING_AW'(r_in.slot);
    // (pos - lag - 1) mod RING_SIZE; wraps by truncation
    assign lag_idx  = r_pos - RING_AW'(r_lag) - RING_AW'(1);
    assign is_draw  = (r_in.op == OP_DRAW);
    assign rd_addr  = is_draw ? lag_idx : slot_idx;
    assign rd_word  = r_ring[rd_addr];

    cmwc_mac u_mac (
        .i_mult  (r_mult),
        .i_word  (rd_word),
        .i_carry (r_carry),
        .o_word  (mac_word),
        .o_carry (mac_carry)
    );

    // Discarded warm-up draws hold the request in place but need no result slot.
    assign warm_busy  = r_warm && (r_wcnt != r_lag);
    assign out_ready  = !r_out_vld || !i_out_stall;
    assign consume    = r_in_vld && !(is_draw && warm_busy) && out_ready;
    assign do_draw    = r_in_vld && is_draw && (warm_busy || out_ready);
    assign in_take    = i_in_valid && !o_in_stall;
    // no request is taken while reset is asserted
    assign o_in_stall = !i_rst_n || (r_in_vld && !consume);

    // Next state and result word for the request in the first stage
    always_comb begin
        n_carry = r_carry;
        n_pos   = r_pos;
        n_warm  = r_warm;
        n_word  = rd_word;
        case (r_in.op)
            OP_DRAW: begin
                n_carry = mac_carry;
                n_pos   = r_pos + RING_AW'(1);
                n_word  = mac_word;
                if (!warm_busy) begin
                    n_warm = 1'b0;
                end
            end
            OP_WRITE: begin
                n_warm = 1'b0;
                n_word = r_in.load_value;
            end
            OP_SET: begin
                n_carry = r_in.load_value;
                n_pos   = slot_idx;
                n_warm  = 1'b0;
            end
            OP_READ: begin
                n_word = rd_word;
            end
            default: begin
                n_word = rd_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RING_SIZE; i++) begin
                r_ring[i] <= WORD_W'(i);
            end
            r_carry   <= '0;
            r_pos     <= '0;
            r_warm    <= 1'b1;
            r_wcnt    <= '0;
            r_mult    <= MULT_RESET;
            r_lag     <= LAG_RESET;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            // configuration: the user must write it only while the block is idle; the block does not enforce this
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MULT: r_mult <= i_cfg_data;
                    CFG_LAG:  r_lag  <= i_cfg_data[LAG_W-1:0];
                    default:  r_lag  <= r_lag;
                endcase
            end

            // state update
            if (do_draw) begin
                r_ring[r_pos] <= mac_word;
                r_carry       <= n_carry;
                r_pos         <= n_pos;
                r_warm        <= n_warm;
                if (warm_busy) begin
                    r_wcnt <= r_wcnt + LAG_W'(1);
                end
            end else if (consume) begin
                if (r_in.op == OP_WRITE) begin
                    r_ring[slot_idx] <= r_in.load_value;
                end
                r_carry <= n_carry;
                r_pos   <= n_pos;
                r_warm  <= n_warm;
            end

            // request register
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (consume) begin
                r_in_vld <= 1'b0;
            end

            // result register
            if (consume) begin
                r_out_vld <= 1'b1;
            end else if (out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in;
        end
        if (consume) begin
            r_out.out_word     <= n_word;
            r_out.out_carry    <= n_carry;
            r_out.out_position <= POS_W'(n_pos);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // ---- assertions ----
    // warm-up, once cleared, never comes back without reset
    `ASSERT_NEXT(a_warm_sticky, i_clk, i_rst_n, !r_warm, !r_warm)
    // every draw advances the write position by one
    `ASSERT_NEXT(a_draw_adv, i_clk, i_rst_n, do_draw,
                 r_pos == $past(r_pos) + RING_AW'(1))
    // a new result only comes from a request held in the first stage
    `ASSERT_CLK(a_out_src, i_clk, i_rst_n, $rose(r_out_vld) |-> $past(r_in_vld))
    // warm-up draws never retire the request
    `ASSERT_CLK(a_warm_hold, i_clk, i_rst_n, (r_in_vld && is_draw && warm_busy) |-> !consume)

endmodule
